// ===== hdl/pcxd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants of the PCX scanline run-length decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

  // widest scanline the decoder supports
  localparam int unsigned MAX_LINE_WIDTH = 65536;

  localparam int unsigned WIDTH_BITS = 17;
  localparam int unsigned BYTES_BITS = 18;

  // run header marker and count mask
  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  // byte counter stops here
  localparam logic [BYTES_BITS-1:0] BYTES_SAT = 18'h20000;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 17'd320;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_LINE_WIDTH);

  // command queue depth between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_BITS = $clog2(CMD_DEPTH);

  // register byte addresses
  localparam int unsigned ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_LINE_WIDTH = 3'd0;

  // command operations
  typedef enum logic [1:0] {
    OP_SKIP = 2'd0,  // byte counted, no pixel
    OP_LIT  = 2'd1,  // one literal pixel
    OP_RUN  = 2'd2   // run of count pixels
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] count;
    logic [7:0] value;
  } cmd_t;

endpackage

// ===== hdl/pcxd_front.sv =====
// ----------------------------------------------------------------------------
// pcxd_front
// Accepts encoded bytes and classifies them into skip, literal and run
// commands for the back end.
// ----------------------------------------------------------------------------
module pcxd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    code_byte,
  output logic          full,
  input  logic          cmd_full,
  output logic          cmd_wr,
  output pcxd_pkg::cmd_t cmd_data
);

  logic       await_value;
  logic [5:0] run_count;
  logic       accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign cmd_wr = accept;

  // classify the incoming beat
  always_comb begin
    cmd_data.op    = pcxd_pkg::OP_LIT;
    cmd_data.count = 6'd1;
    cmd_data.value = code_byte;
    if (await_value) begin
      cmd_data.count = run_count;
      cmd_data.op    = (run_count == 6'd0) ? pcxd_pkg::OP_SKIP : pcxd_pkg::OP_RUN;
    end else if ((code_byte & pcxd_pkg::RUN_MARK) == pcxd_pkg::RUN_MARK) begin
      cmd_data.op = pcxd_pkg::OP_SKIP;
    end
  end

  // run header tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      await_value <= 1'b0;
      run_count   <= 6'd0;
    end else if (accept) begin
      if (await_value) begin
        await_value <= 1'b0;
        run_count   <= 6'd0;
      end else if ((code_byte & pcxd_pkg::RUN_MARK) == pcxd_pkg::RUN_MARK) begin
        await_value <= 1'b1;
        run_count   <= code_byte[5:0] & pcxd_pkg::RUN_MASK[5:0];
      end
    end
  end

endmodule

// ===== hdl/pcxd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// pcxd_cmd_queue
// Small register queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module pcxd_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pcxd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output pcxd_pkg::cmd_t rd_data,
  output logic           empty
);

  pcxd_pkg::cmd_t                     slots [pcxd_pkg::CMD_DEPTH];
  logic [pcxd_pkg::CMD_PTR_BITS-1:0] wptr;
  logic [pcxd_pkg::CMD_PTR_BITS-1:0] rptr;
  logic [pcxd_pkg::CMD_PTR_BITS:0]   count;
  logic                              do_wr;
  logic                              do_rd;

  assign full    = (count == (pcxd_pkg::CMD_PTR_BITS+1)'(pcxd_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/pcxd_back.sv =====
// ----------------------------------------------------------------------------
// pcxd_back
// Executes commands: counts encoded bytes, emits pixels, closes lines at the
// configured width, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module pcxd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pcxd_pkg::WIDTH_BITS-1:0]   line_width,
  input  logic                              cmd_empty,
  input  pcxd_pkg::cmd_t                    cmd_data,
  output logic                              cmd_rd,
  input  logic                              pop,
  output logic                              empty,
  output logic [7:0]                        pixel,
  output logic                              line_end,
  output logic [pcxd_pkg::BYTES_BITS-1:0]   bytes_used
);

  typedef struct packed {
    logic [7:0]                      pixel;
    logic                            line_end;
    logic [pcxd_pkg::BYTES_BITS-1:0] bytes_used;
  } result_t;

  logic                            active;
  logic [5:0]                      remaining;
  logic [7:0]                      value;
  logic [pcxd_pkg::WIDTH_BITS-1:0] pixels_done;
  logic [pcxd_pkg::BYTES_BITS-1:0] bytes_taken;

  result_t    oq [2];
  logic       owptr;
  logic       orptr;
  logic [1:0] ocount;

  logic [pcxd_pkg::WIDTH_BITS-1:0] eff_width;
  logic [pcxd_pkg::WIDTH_BITS:0]   done_plus;
  logic                            emit;
  logic                            last;
  logic                            do_pop;
  result_t                         res;

  // clamp the configured width
  always_comb begin
    eff_width = line_width;
    if (line_width == '0) begin
      eff_width = pcxd_pkg::WIDTH_BITS'(1);
    end else if (line_width > pcxd_pkg::WIDTH_MAX) begin
      eff_width = pcxd_pkg::WIDTH_MAX;
    end
  end

  assign done_plus = {1'b0, pixels_done} + 1'b1;
  assign last      = (done_plus >= {1'b0, eff_width});
  assign emit      = active && (ocount != 2'd2);
  assign cmd_rd    = !active && !cmd_empty;
  assign do_pop    = pop && (ocount != 2'd0);

  // result of the pixel in flight
  always_comb begin
    res.pixel      = value;
    res.line_end   = last;
    res.bytes_used = last ? bytes_taken : '0;
  end

  // command execution
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      remaining   <= 6'd0;
      value       <= 8'd0;
      pixels_done <= '0;
      bytes_taken <= '0;
    end else if (cmd_rd) begin
      if (bytes_taken != pcxd_pkg::BYTES_SAT) begin
        bytes_taken <= bytes_taken + 1'b1;
      end
      value <= cmd_data.value;
      case (cmd_data.op)
        pcxd_pkg::OP_LIT: begin
          active    <= 1'b1;
          remaining <= 6'd1;
        end
        pcxd_pkg::OP_RUN: begin
          active    <= (cmd_data.count != 6'd0);
          remaining <= cmd_data.count;
        end
        default: begin
          active    <= 1'b0;
          remaining <= 6'd0;
        end
      endcase
    end else if (emit) begin
      if (last) begin
        // line closed, rest of the run is dropped
        pixels_done <= '0;
        bytes_taken <= '0;
        active      <= 1'b0;
        remaining   <= 6'd0;
      end else begin
        pixels_done <= done_plus[pcxd_pkg::WIDTH_BITS-1:0];
        remaining   <= remaining - 1'b1;
        active      <= (remaining != 6'd1);
      end
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      oq[owptr] <= res;
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (emit) begin
        owptr <= ~owptr;
      end
      if (do_pop) begin
        orptr <= ~orptr;
      end
      case ({emit, do_pop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

  assign empty      = (ocount == 2'd0);
  assign pixel      = oq[orptr].pixel;
  assign line_end   = oq[orptr].line_end;
  assign bytes_used = oq[orptr].bytes_used;

endmodule

// ===== hdl/pcx_rle_line_decoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder
// PCX scanline run-length decoder with an APB-style width register.
// ----------------------------------------------------------------------------
// Encoded bytes go in through push/full, decoded pixels come out through
// empty/pop, oldest first. A front end classifies each byte into a command
// and a four-entry command queue feeds the back end, which takes one command
// per cycle when it is free and then emits one pixel per cycle while the
// output queue has room; the pixel rate of the back end sets the throughput.
// A two-entry output queue lets input continue while results wait.
// line_width sits at byte address 0; write it only while the block is idle.
module pcx_rle_line_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcxd_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              push,
  input  logic [7:0]                        code_byte,
  output logic                              full,
  input  logic                              pop,
  output logic                              empty,
  output logic [7:0]                        pixel,
  output logic                              line_end,
  output logic [pcxd_pkg::BYTES_BITS-1:0]   bytes_used
);

  logic [pcxd_pkg::WIDTH_BITS-1:0] line_width;
  logic                            cmd_wr;
  logic                            cmd_rd;
  logic                            cmd_full;
  logic                            cmd_empty;
  pcxd_pkg::cmd_t                  cmd_in;
  pcxd_pkg::cmd_t                  cmd_out;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= pcxd_pkg::WIDTH_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == pcxd_pkg::REG_LINE_WIDTH[2])) begin
      line_width <= pwdata[pcxd_pkg::WIDTH_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == pcxd_pkg::REG_LINE_WIDTH[2])
                  ? {{(32 - pcxd_pkg::WIDTH_BITS){1'b0}}, line_width} : 32'd0;

  pcxd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .code_byte (code_byte),
    .full      (full),
    .cmd_full  (cmd_full),
    .cmd_wr    (cmd_wr),
    .cmd_data  (cmd_in)
  );

  pcxd_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  pcxd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_out),
    .cmd_rd     (cmd_rd),
    .pop        (pop),
    .empty      (empty),
    .pixel      (pixel),
    .line_end   (line_end),
    .bytes_used (bytes_used)
  );

endmodule
